// File: rtl/dsw_pkg.sv
// Shared types, constants and modular arithmetic helpers for the dice sum
// ways counter. No dependencies; used by every module under rtl but dsw_ram.
package dsw_pkg;

   localparam int MAX_DICE  = 32;
   localparam int MAX_FACES = 32;
   localparam int SUM_DEPTH = 1024;

   localparam int DICE_W    = 6;
   localparam int FACES_W   = 6;
   localparam int GOAL_W    = 10;
   localparam int WAYS_W    = 30;
   localparam int REQ_W     = 24;
   localparam int RSP_W     = 32;

   localparam int IDX_W     = $clog2(SUM_DEPTH);
   localparam int ROW_DEPTH = 2 * SUM_DEPTH;
   localparam int ADDR_W    = $clog2(ROW_DEPTH);

   localparam logic [WAYS_W-1:0] WAYS_MOD = WAYS_W'(1000000007);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_START,
      ST_ROW,
      ST_DRAIN,
      ST_FINISH
   } ctrl_state_type;

   typedef struct packed {
      logic load;
      logic row_start;
      logic step;
      logic row_next;
      logic finish;
   } dp_cmd_type;

   typedef struct packed {
      logic item_ok;
      logic last_step;
      logic last_row;
      logic busy;
      logic out_free;
   } dp_status_type;

   // (a + b) mod M for a, b below M
   function automatic logic [WAYS_W-1:0] mod_add(input logic [WAYS_W-1:0] a,
                                                 input logic [WAYS_W-1:0] b);
      logic [WAYS_W:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      if (sum >= {1'b0, WAYS_MOD}) begin
         sum = sum - {1'b0, WAYS_MOD};
      end
      return sum[WAYS_W-1:0];
   endfunction

   // (a - b) mod M for a, b below M
   function automatic logic [WAYS_W-1:0] mod_sub(input logic [WAYS_W-1:0] a,
                                                 input logic [WAYS_W-1:0] b);
      logic [WAYS_W:0] dif;
      if (a >= b) begin
         dif = {1'b0, a} - {1'b0, b};
      end else begin
         dif = {1'b0, a} + {1'b0, WAYS_MOD} - {1'b0, b};
      end
      return dif[WAYS_W-1:0];
   endfunction

endpackage

// File: rtl/dice_sum_ways_counter_unit.sv
// Dice sum ways counter. Each request carries dice, faces and goal; the response
// is the number of ordered rolls reaching goal, modulo 1000000007 (0 for a goal
// of zero or a dice or face count outside 1..32). The table is built one entry
// per cycle within each row through a single row RAM with two read ports; the
// window sum pipeline is drained at the end of each row before the next begins.
// One request is worked at a time; a finished response waits in its output
// register while the next request is accepted. Uses dsw_pkg, dsw_controller and
// dsw_datapath.
module dice_sum_ways_counter_unit
   import dsw_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [REQ_W-1:0] req_tdata,   // dice[5:0], faces[11:6], goal[21:12], zeros
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata    // ways[29:0], zeros
);

   dp_cmd_type    cmd;
   dp_status_type status;

   dsw_controller u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   dsw_datapath u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .cmd        (cmd),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// File: rtl/dsw_ram.sv
// Generic single-write, dual-read RAM with registered read data.
// No dependencies; holds the two table rows of the ways counter.
module dsw_ram #(
   parameter int WIDTH = 30,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   output logic [WIDTH-1:0]         rd_data_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem_ff[rd_addr_a];
      rd_b_ff <= mem_ff[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

// File: rtl/dsw_datapath.sv
// Datapath of the ways counter: operand registers, loop counters, the row
// RAM, the window sum pipeline and the result register. Uses dsw_pkg, dsw_ram.
module dsw_datapath
   import dsw_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic [REQ_W-1:0]    req_tdata,
   input  dp_cmd_type          cmd,
   output dp_status_type       status,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [RSP_W-1:0]    rsp_tdata
);

   logic [DICE_W-1:0]  dice_ff;
   logic [FACES_W-1:0] faces_ff;
   logic [GOAL_W-1:0]  goal_ff;
   logic [IDX_W-1:0]   step_ff;
   logic [DICE_W-1:0]  die_ff;
   logic               row_ff;
   logic               first_ff;
   logic [WAYS_W-1:0]  window_ff;
   logic [WAYS_W-1:0]  window_in;

   // stage 1: read issued, RAM data arrives next cycle
   logic               v1_ff;
   logic               a_mem1_ff, a_one1_ff, b_mem1_ff, b_one1_ff;
   logic [ADDR_W-1:0]  waddr1_ff;
   // stage 2: difference of the two window edges
   logic               v2_ff;
   logic [WAYS_W-1:0]  diff_ff;
   logic [ADDR_W-1:0]  waddr2_ff;

   logic [WAYS_W-1:0]  rsp_data_ff;
   logic               rsp_valid_ff;

   logic [IDX_W-1:0]   a_idx, b_idx;
   logic               a_zero, b_zero, b_live;
   logic [WAYS_W-1:0]  rd_a, rd_b, a_val, b_val, diff_in;
   logic               item_ok;

   assign a_idx  = step_ff - IDX_W'(1);
   assign b_idx  = step_ff - IDX_W'(faces_ff) - IDX_W'(1);
   assign a_zero = (a_idx == '0);
   assign b_zero = (b_idx == '0);
   assign b_live = (step_ff > IDX_W'(faces_ff));

   assign item_ok = (dice_ff != '0) && (faces_ff != '0) &&
                    (dice_ff <= DICE_W'(MAX_DICE)) && (faces_ff <= FACES_W'(MAX_FACES)) &&
                    (int'(goal_ff) < SUM_DEPTH) && (goal_ff != '0);

   dsw_ram #(
      .WIDTH (WAYS_W),
      .DEPTH (ROW_DEPTH)
   ) u_rows (
      .clock     (clock),
      .wr_en     (v2_ff),
      .wr_addr   (waddr2_ff),
      .wr_data   (window_in),
      .rd_addr_a ({row_ff, a_idx}),
      .rd_data_a (rd_a),
      .rd_addr_b ({row_ff, b_idx}),
      .rd_data_b (rd_b)
   );

   // row zero and entry zero of every row are not stored
   assign a_val   = a_mem1_ff ? rd_a : {{(WAYS_W-1){1'b0}}, a_one1_ff};
   assign b_val   = b_mem1_ff ? rd_b : {{(WAYS_W-1){1'b0}}, b_one1_ff};
   assign diff_in = mod_sub(a_val, b_val);
   assign window_in = mod_add(window_ff, diff_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
         row_ff       <= 1'b0;
         first_ff     <= 1'b0;
      end else begin
         v1_ff <= cmd.step;
         v2_ff <= v1_ff;
         if (cmd.finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (cmd.load) begin
            first_ff <= 1'b1;
         end else if (cmd.row_next) begin
            first_ff <= 1'b0;
            row_ff   <= ~row_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         dice_ff  <= req_tdata[DICE_W-1:0];
         faces_ff <= req_tdata[DICE_W +: FACES_W];
         goal_ff  <= req_tdata[DICE_W+FACES_W +: GOAL_W];
         die_ff   <= '0;
      end
      if (cmd.row_next) begin
         die_ff <= die_ff + DICE_W'(1);
      end
      if (cmd.row_start || cmd.row_next) begin
         step_ff   <= IDX_W'(1);
         window_ff <= '0;
      end else begin
         if (cmd.step) begin
            step_ff <= step_ff + IDX_W'(1);
         end
         if (v2_ff) begin
            window_ff <= window_in;
         end
      end
      a_mem1_ff <= !first_ff && !a_zero;
      a_one1_ff <= first_ff && a_zero;
      b_mem1_ff <= b_live && !first_ff && !b_zero;
      b_one1_ff <= b_live && first_ff && b_zero;
      waddr1_ff <= {~row_ff, step_ff};
      diff_ff   <= diff_in;
      waddr2_ff <= waddr1_ff;
      if (cmd.finish) begin
         rsp_data_ff <= item_ok ? window_ff : '0;
      end
   end

   assign status.item_ok   = item_ok;
   assign status.last_step = (step_ff == goal_ff);
   assign status.last_row  = ((die_ff + DICE_W'(1)) == dice_ff);
   assign status.busy      = v1_ff || v2_ff;
   assign status.out_free  = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_W-WAYS_W){1'b0}}, rsp_data_ff};

endmodule

// File: rtl/dsw_controller.sv
// Sequencer of the ways counter: walks rows and steps, drains the window
// pipeline between rows and hands the result to the output register. Uses dsw_pkg.
module dsw_controller
   import dsw_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_START;
            end
         end
         ST_START: begin
            if (status.item_ok) begin
               cmd.row_start = 1'b1;
               state_in      = ST_ROW;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_ROW: begin
            cmd.step = 1'b1;
            if (status.last_step) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            // hold until the last write of the row has landed
            if (!status.busy) begin
               if (status.last_row) begin
                  state_in = ST_FINISH;
               end else begin
                  cmd.row_next = 1'b1;
                  state_in     = ST_ROW;
               end
            end
         end
         ST_FINISH: begin
            if (status.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// File: tb/testbench.sv
// Self-checking testbench for dice_sum_ways_counter_unit: directed corner cases,
// output back-pressure and random roll requests, each checked against a local
// table-building predictor. Depends on dsw_pkg and the unit's RTL only.
module testbench
   import dsw_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [31:0] WAYS_PRIME = 32'd1000000007;

   typedef struct packed {
      logic [GOAL_W-1:0]  goal;
      logic [FACES_W-1:0] faces;
      logic [DICE_W-1:0]  dice;
   } roll_req_type;

   logic             clock = 1'b0;
   logic             reset;
   logic             req_tvalid;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata;    // dice[5:0], faces[11:6], goal[21:12], zeros
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;    // ways[29:0], zeros

   logic [WAYS_W-1:0] ways_due[$];
   logic [WAYS_W-1:0] partial_row[2][SUM_DEPTH];
   int                fail_count = 0;
   bit                idle_on = 1'b1;
   bit                rsp_hold = 1'b0;
   int                rsp_gap_left = 0;

   dice_sum_ways_counter_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Count ordered rolls reaching goal, mod the prime, one die per table row.
   function automatic logic [WAYS_W-1:0] count_rolls(input roll_req_type r);
      logic [31:0] window;
      int          prev;
      int          cur;
      int          k;
      int          s;
      int          f;
      int          g;
      f = int'(r.faces);
      g = int'(r.goal);
      if (r.dice == 0 || r.faces == 0 || int'(r.dice) > MAX_DICE || f > MAX_FACES ||
          g == 0) begin
         return '0;
      end
      for (s = 0; s <= g; s++) begin
         partial_row[0][s] = (s == 0) ? WAYS_W'(1) : '0;
      end
      prev = 0;
      for (k = 0; k < int'(r.dice); k++) begin
         cur = 1 - prev;
         window = '0;
         partial_row[cur][0] = '0;
         for (s = 1; s <= g; s++) begin
            window = window + 32'(partial_row[prev][s-1]);
            if (window >= WAYS_PRIME) begin
               window = window - WAYS_PRIME;
            end
            // drop the entry that slides out of the window
            if (s > f) begin
               if (window >= 32'(partial_row[prev][s-1-f])) begin
                  window = window - 32'(partial_row[prev][s-1-f]);
               end else begin
                  window = window + WAYS_PRIME - 32'(partial_row[prev][s-1-f]);
               end
            end
            partial_row[cur][s] = window[WAYS_W-1:0];
         end
         prev = cur;
      end
      return partial_row[prev][g];
   endfunction

   task automatic flag_failure(input string what);
      fail_count++;
      if (fail_count <= 10) begin
         $display("%0t ns: %s", $time, what);
      end
   endtask

   // Offer one request and hold it until the unit takes it.
   task automatic send_roll(input int dice, input int faces, input int goal);
      roll_req_type r;
      r.dice  = DICE_W'(dice);
      r.faces = FACES_W'(faces);
      r.goal  = GOAL_W'(goal);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {2'b00, r};
      do @(posedge clock); while (!req_tready);
      ways_due = {ways_due, count_rolls(r)};
   endtask

   task automatic wait_drain();
      req_tvalid <= 1'b0;
      while (ways_due.size() != 0) @(posedge clock);
   endtask

   // Response side: random stalls of rsp_tready, plus the long hold-off.
   always @(posedge clock) begin
      if (reset || rsp_hold) begin
         rsp_tready <= 1'b0;
      end else if (rsp_gap_left != 0) begin
         rsp_tready   <= 1'b0;
         rsp_gap_left <= rsp_gap_left - 1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
         rsp_tready   <= 1'b0;
         rsp_gap_left <= $urandom_range(0, 2);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      logic [WAYS_W-1:0] want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (ways_due.size() == 0) begin
            flag_failure($sformatf("unexpected response ways=%0d", rsp_tdata[WAYS_W-1:0]));
         end else begin
            want = ways_due.pop_front();
            if (rsp_tdata[WAYS_W-1:0] !== want) begin
               flag_failure($sformatf("ways mismatch: expected %0d, got %0d",
                                      want, rsp_tdata[WAYS_W-1:0]));
            end
         end
      end
   end

   task automatic test_corner_cases();
      send_roll(3, 6, 0);        // goal of zero
      send_roll(1, 6, 1);        // one die, lowest goal
      send_roll(1, 6, 6);
      send_roll(1, 6, 7);        // one die, goal past the faces
      send_roll(1, 1, 1);
      send_roll(2, 6, 7);
      send_roll(2, 6, 12);
      send_roll(2, 6, 13);       // goal beyond dice times faces
      send_roll(5, 1, 5);
      send_roll(5, 1, 4);
      send_roll(0, 6, 5);        // zero dice
      send_roll(3, 0, 5);        // zero faces
      send_roll(33, 6, 10);      // dice out of range
      send_roll(3, 33, 10);      // faces out of range
      send_roll(63, 63, 1023);
      send_roll(1, 32, 32);
      send_roll(32, 1, 32);
      send_roll(32, 32, 32);
      send_roll(32, 32, 528);    // count far above the modulus
      send_roll(32, 32, 1023);
      send_roll(4, 32, 1023);
      wait_drain();
   endtask

   // Stall the response side long enough that the unit backs up its input.
   task automatic test_backpressure();
      int n;
      fork
         begin
            rsp_hold <= 1'b1;
            repeat (400) @(posedge clock);
            rsp_hold <= 1'b0;
         end
      join_none
      for (n = 0; n < 8; n++) begin
         send_roll($urandom_range(1, 3), $urandom_range(1, 8), $urandom_range(0, 20));
      end
      wait_drain();
   endtask

   task automatic test_random_rolls();
      int n;
      int d;
      int f;
      int g;
      int top;
      for (n = 0; n < 71; n++) begin
         if (n == 56) begin
            idle_on <= 1'b0;
         end
         if (n % 10 == 9) begin
            // full-size table, goal mostly within reach
            d = $urandom_range(1, MAX_DICE);
            f = $urandom_range(1, MAX_FACES);
            top = (d * f + 2 > SUM_DEPTH - 1) ? SUM_DEPTH - 1 : d * f + 2;
            g = $urandom_range(0, top);
         end else if ($urandom_range(0, 9) == 0) begin
            // out-of-range dice or faces
            d = $urandom_range(0, 63);
            f = $urandom_range(0, 63);
            if ($urandom_range(0, 1) == 1) begin
               d = ($urandom_range(0, 1) == 1) ? 0 : $urandom_range(MAX_DICE + 1, 63);
            end else begin
               f = ($urandom_range(0, 1) == 1) ? 0 : $urandom_range(MAX_FACES + 1, 63);
            end
            g = $urandom_range(0, SUM_DEPTH - 1);
         end else begin
            d = $urandom_range(1, 6);
            f = $urandom_range(1, MAX_FACES);
            top = (d * f + 2 > 60) ? 60 : d * f + 2;
            g = $urandom_range(0, top);
         end
         send_roll(d, f, g);
      end
      wait_drain();
   endtask

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_corner_cases();
      test_backpressure();
      test_random_rolls();
      repeat (50) @(posedge clock);
      if (fail_count == 0 && ways_due.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin
      #25_000_000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule
